@@ src/pfx_pkg.sv @@
`default_nettype none

package pfx_pkg;

	localparam int DATA_W      = 32;
	localparam int SYM_W       = 8;
	localparam int STAT_W      = 2;
	localparam int DEPTH_DFLT  = 64;

	localparam logic [SYM_W-1:0] SYM_ZERO = 8'd48;
	localparam logic [SYM_W-1:0] SYM_ADD  = 8'd43;
	localparam logic [SYM_W-1:0] SYM_SUB  = 8'd45;
	localparam logic [SYM_W-1:0] SYM_MUL  = 8'd42;
	localparam logic [SYM_W-1:0] SYM_DIV  = 8'd47;
	localparam logic [SYM_W-1:0] SYM_XOR  = 8'd94;

	localparam logic [STAT_W-1:0] STAT_OK    = 2'd0;
	localparam logic [STAT_W-1:0] STAT_UNDER = 2'd1;
	localparam logic [STAT_W-1:0] STAT_DIVZ  = 2'd2;
	localparam logic [STAT_W-1:0] STAT_FULL  = 2'd3;

	typedef enum logic [2:0] {
		S_IDLE,
		S_EXEC,
		S_DIV,
		S_WB,
		S_OUT
	} state_t;

	// shift command shared by every cell of the stack
	typedef struct packed {
		logic push;
		logic pop;
	} cell_ctl_t;

endpackage

`default_nettype wire

@@ src/pfx_cell.sv @@
`default_nettype none

// one stack entry: takes the entry above on push, the entry below on pop
module pfx_cell import pfx_pkg::*; (
	input  wire logic              clk,
	input  wire cell_ctl_t         ctl,
	input  wire logic [DATA_W-1:0] above,
	input  wire logic [DATA_W-1:0] below,
	output logic      [DATA_W-1:0] q
);

	logic [DATA_W-1:0] entry_q;

	always_ff @(posedge clk) begin
		if (ctl.push) begin
			entry_q <= above;
		end else if (ctl.pop) begin
			entry_q <= below;
		end
	end

	assign q = entry_q;

endmodule

`default_nettype wire

@@ src/pfx_div.sv @@
`default_nettype none

// signed divide, truncating toward zero, one quotient bit per cycle
module pfx_div import pfx_pkg::*; (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              start,
	input  wire logic [DATA_W-1:0] dividend,
	input  wire logic [DATA_W-1:0] divisor,
	output logic                   done,
	output logic      [DATA_W-1:0] quotient
);

	localparam int CNT_W = $clog2(DATA_W);

	logic              busy_q;
	logic              done_q;
	logic [CNT_W-1:0]  cnt_q;
	logic [DATA_W-1:0] rem_q;
	logic [DATA_W-1:0] dvd_q;
	logic [DATA_W-1:0] den_q;
	logic              neg_q;
	logic [DATA_W:0]   shifted;
	logic [DATA_W:0]   diff;
	logic              fits;

	assign shifted = {rem_q, dvd_q[DATA_W-1]};
	assign diff    = shifted - {1'b0, den_q};
	assign fits    = shifted >= {1'b0, den_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + CNT_W'(1);
				if (cnt_q == CNT_W'(DATA_W - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			// magnitudes; the most negative value maps to its unsigned magnitude
			dvd_q <= dividend[DATA_W-1] ? (~dividend + DATA_W'(1)) : dividend;
			den_q <= divisor[DATA_W-1] ? (~divisor + DATA_W'(1)) : divisor;
			neg_q <= dividend[DATA_W-1] ^ divisor[DATA_W-1];
			rem_q <= '0;
		end else if (busy_q) begin
			rem_q <= fits ? diff[DATA_W-1:0] : shifted[DATA_W-1:0];
			dvd_q <= {dvd_q[DATA_W-2:0], fits};
		end
	end

	assign done     = done_q;
	assign quotient = neg_q ? (~dvd_q + DATA_W'(1)) : dvd_q;

endmodule

`default_nettype wire

@@ src/postfix_expression_evaluator_unit.sv @@
`default_nettype none

// Postfix expression evaluator. Characters arrive one per transfer on the slave
// side; the operand stack is a row of STACK_DEPTH register cells with the top of
// stack in the first cell, shifted down on a push and up on an operator.
// One character is taken at a time: an operand, + - or ^ is done in EXEC, *
// passes through WB as well (registered multiplier), / waits in DIV until
// the shift-subtract divider is done (it produces one quotient bit per cycle);
// an operator that finds fewer than two entries, or a divide by a zero divisor,
// is done in EXEC. A character flagged by tlast then passes through OUT to load
// the result register, and waits there while the previous result is not taken.
// The result (value in tdata, status in tuser) sits in an output register, so
// the next expression can start while it waits to be taken. There is no clearing
// pass after reset.
module postfix_expression_evaluator_unit import pfx_pkg::*; #(
	parameter int STACK_DEPTH = DEPTH_DFLT
) (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                s_tvalid,
	output logic                     s_tready,
	input  wire logic [SYM_W-1:0]    s_tdata,  // [7:0] symbol
	input  wire logic                s_tlast,  // last_symbol
	output logic                     m_tvalid,
	input  wire logic                m_tready,
	output logic      [DATA_W-1:0]   m_tdata,  // [31:0] value
	output logic      [STAT_W-1:0]   m_tuser   // [1:0] status
);

	localparam int CW = $clog2(STACK_DEPTH + 1);

	state_t            state_q, state_d;
	logic [SYM_W-1:0]  sym_q;
	logic              last_q;
	logic [CW-1:0]     count_q;
	logic [STAT_W-1:0] err_q;
	logic [DATA_W-1:0] res_q;
	logic              out_valid_q;
	logic [DATA_W-1:0] out_value_q;
	logic [STAT_W-1:0] out_status_q;

	cell_ctl_t         ctl;
	logic [DATA_W-1:0] din;
	logic [DATA_W-1:0] cell_q [STACK_DEPTH];
	logic [DATA_W-1:0] top_w;
	logic [DATA_W-1:0] nxt_w;

	logic              is_op;
	logic              full;
	logic              cnt_inc;
	logic              cnt_dec;
	logic              err_set;
	logic [STAT_W-1:0] err_code;
	logic              res_load;
	logic              div_start;
	logic              div_done;
	logic [DATA_W-1:0] div_q;
	logic              out_load;
	logic [STAT_W-1:0] fin_status;
	logic [DATA_W-1:0] fin_value;
	state_t            after_exec;

	assign top_w = cell_q[0];
	assign nxt_w = cell_q[1];

	// row of stack cells, the first one fed from the datapath
	for (genvar gi = 0; gi < STACK_DEPTH; gi++) begin : g_cell
		if (gi == 0) begin : g_top
			pfx_cell u_cell (
				.clk   (clk),
				.ctl   (ctl),
				.above (din),
				.below (din),
				.q     (cell_q[gi])
			);
		end else if (gi == STACK_DEPTH - 1) begin : g_bot
			pfx_cell u_cell (
				.clk   (clk),
				.ctl   (ctl),
				.above (cell_q[gi-1]),
				.below (cell_q[gi]),
				.q     (cell_q[gi])
			);
		end else begin : g_mid
			pfx_cell u_cell (
				.clk   (clk),
				.ctl   (ctl),
				.above (cell_q[gi-1]),
				.below (cell_q[gi+1]),
				.q     (cell_q[gi])
			);
		end
	end

	pfx_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (nxt_w),
		.divisor  (top_w),
		.done     (div_done),
		.quotient (div_q)
	);

	always_comb begin
		is_op = sym_q inside {SYM_ADD, SYM_SUB, SYM_MUL, SYM_DIV, SYM_XOR};
	end

	assign full       = count_q == CW'(STACK_DEPTH);
	assign after_exec = last_q ? S_OUT : S_IDLE;

	// an empty stack at the end counts as underflow unless an error is already held
	assign fin_status = (count_q == '0 && err_q == STAT_OK) ? STAT_UNDER : err_q;
	assign fin_value  = (fin_status == STAT_UNDER || count_q == '0) ? '0 : top_w;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d   = state_q;
		s_tready  = 1'b0;
		ctl       = '0;
		din       = res_q;
		cnt_inc   = 1'b0;
		cnt_dec   = 1'b0;
		err_set   = 1'b0;
		err_code  = STAT_OK;
		res_load  = 1'b0;
		div_start = 1'b0;
		out_load  = 1'b0;
		unique case (state_q)
			S_IDLE: begin
				s_tready = 1'b1;
				if (s_tvalid) begin
					state_d = S_EXEC;
				end
			end
			S_EXEC: begin
				state_d = after_exec;
				if (!is_op) begin
					din = DATA_W'(sym_q) - DATA_W'(SYM_ZERO);
					if (full) begin
						err_set  = 1'b1;
						err_code = STAT_FULL;
					end else begin
						ctl.push = 1'b1;
						cnt_inc  = 1'b1;
					end
				end else if (count_q < CW'(2)) begin
					err_set  = 1'b1;
					err_code = STAT_UNDER;
				end else begin
					unique case (sym_q)
						SYM_ADD: begin
							din     = nxt_w + top_w;
							ctl.pop = 1'b1;
							cnt_dec = 1'b1;
						end
						SYM_SUB: begin
							din     = nxt_w - top_w;
							ctl.pop = 1'b1;
							cnt_dec = 1'b1;
						end
						SYM_MUL: begin
							res_load = 1'b1;
							state_d  = S_WB;
						end
						SYM_DIV: begin
							if (top_w == '0) begin
								din      = '0;
								ctl.pop  = 1'b1;
								cnt_dec  = 1'b1;
								err_set  = 1'b1;
								err_code = STAT_DIVZ;
							end else begin
								div_start = 1'b1;
								state_d   = S_DIV;
							end
						end
						default: begin
							din     = nxt_w ^ top_w;
							ctl.pop = 1'b1;
							cnt_dec = 1'b1;
						end
					endcase
				end
			end
			S_DIV: begin
				din = div_q;
				if (div_done) begin
					ctl.pop = 1'b1;
					cnt_dec = 1'b1;
					state_d = after_exec;
				end
			end
			S_WB: begin
				ctl.pop = 1'b1;
				cnt_dec = 1'b1;
				state_d = after_exec;
			end
			S_OUT: begin
				if (!out_valid_q || m_tready) begin
					out_load = 1'b1;
					state_d  = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q     <= '0;
			err_q       <= STAT_OK;
			out_valid_q <= 1'b0;
		end else begin
			if (out_load) begin
				count_q <= '0;
				err_q   <= STAT_OK;
			end else begin
				if (cnt_inc) begin
					count_q <= count_q + CW'(1);
				end else if (cnt_dec) begin
					count_q <= count_q - CW'(1);
				end
				// first error of the expression sticks
				if (err_set && err_q == STAT_OK) begin
					err_q <= err_code;
				end
			end
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			sym_q  <= s_tdata;
			last_q <= s_tlast;
		end
		if (res_load) begin
			res_q <= nxt_w * top_w;
		end
		if (out_load) begin
			out_value_q  <= fin_value;
			out_status_q <= fin_status;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = out_value_q;
	assign m_tuser  = out_status_q;

endmodule

`default_nettype wire

@@ src/pfx_checker.sv @@
`default_nettype none

module pfx_checker import pfx_pkg::*; (
	input wire logic              clk,
	input wire logic              arst_n,
	input wire logic              s_tvalid,
	input wire logic              s_tready,
	input wire logic              s_tlast,
	input wire logic              m_tvalid,
	input wire logic              m_tready,
	input wire logic [DATA_W-1:0] m_tdata,
	input wire logic [STAT_W-1:0] m_tuser
);

	// a stalled result keeps its value and status
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
		else $error("result changed while stalled");

	// underflow always reports a zero value
	a_under_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser == STAT_UNDER |-> m_tdata == '0)
		else $error("underflow result with nonzero value");

	// a character without tlast never produces a result
	a_no_early: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready && !s_tlast |-> ##3 !$rose(m_tvalid))
		else $error("result raised after a non-final character");

	// one character in flight: no new transfer right after one was taken
	a_one_item: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> !s_tready)
		else $error("second character taken while one is in flight");

endmodule

bind postfix_expression_evaluator_unit pfx_checker u_pfx_checker (.*);

`default_nettype wire

@@ sim/tb.sv @@
`timescale 1ns / 100ps

module tb;
	import pfx_pkg::*;

	localparam int DEPTH       = DEPTH_DFLT;
	localparam int N_SYMBOLS   = 650;
	localparam int IDLE_LIMIT  = 4000;
	localparam int HOLD_CYCLES = 400;
	localparam int MAX_SHOWN   = 10;

	localparam logic [SYM_W-1:0] OPERATORS [5] = '{SYM_ADD, SYM_SUB, SYM_MUL, SYM_DIV, SYM_XOR};

	typedef logic [SYM_W-1:0] sym_q_t [$];

	typedef struct packed {
		logic [DATA_W-1:0] value;
		logic [STAT_W-1:0] status;
	} rpn_result_t;

	typedef enum int {RX_FREE, RX_COIN, RX_SPARSE, RX_BURSTY} rx_pattern_t;

	function automatic bit is_operator(logic [SYM_W-1:0] sym);
		return sym == SYM_ADD || sym == SYM_SUB || sym == SYM_MUL ||
			sym == SYM_DIV || sym == SYM_XOR;
	endfunction

	// tracks the operand stack and the sticky status of the expression in flight
	class rpn_stack_tracker;
		logic [DATA_W-1:0] operand_mem [DEPTH];
		int unsigned       operand_cnt;
		logic [STAT_W-1:0] sticky_status;
		rpn_result_t       awaited_results [$];
		int                mismatches;
		int                status_seen [4];

		function new();
			operand_cnt   = 0;
			sticky_status = STAT_OK;
			mismatches    = 0;
			foreach (status_seen[i]) status_seen[i] = 0;
		endfunction

		function void flag_error(logic [STAT_W-1:0] code);
			if (sticky_status == STAT_OK) sticky_status = code;
		endfunction

		function void push_operand(logic [DATA_W-1:0] v);
			if (operand_cnt >= DEPTH) begin
				flag_error(STAT_FULL);
			end else begin
				operand_mem[operand_cnt] = v;
				operand_cnt++;
			end
		endfunction

		function void take_symbol(logic [SYM_W-1:0] sym, logic is_last);
			logic [DATA_W-1:0] a, b, r;
			rpn_result_t res;
			if (!is_operator(sym)) begin
				push_operand(DATA_W'(sym) - DATA_W'(SYM_ZERO));
			end else if (operand_cnt < 2) begin
				flag_error(STAT_UNDER);
			end else begin
				b = operand_mem[operand_cnt - 1];
				a = operand_mem[operand_cnt - 2];
				operand_cnt -= 2;
				case (sym)
					SYM_ADD: r = a + b;
					SYM_SUB: r = a - b;
					SYM_MUL: r = a * b;
					SYM_DIV: begin
						if (b == '0) begin
							flag_error(STAT_DIVZ);
							r = '0;
						end else if (a == {1'b1, {(DATA_W-1){1'b0}}} && b == '1) begin
							// most negative over minus one wraps back onto itself
							r = a;
						end else begin
							r = $signed(a) / $signed(b);
						end
					end
					default: r = a ^ b;
				endcase
				push_operand(r);
			end
			if (is_last) begin
				if (operand_cnt == 0) flag_error(STAT_UNDER);
				res.status = sticky_status;
				res.value  = (sticky_status == STAT_UNDER || operand_cnt == 0) ?
					'0 : operand_mem[operand_cnt - 1];
				awaited_results.push_back(res);
				operand_cnt   = 0;
				sticky_status = STAT_OK;
			end
		endfunction

		function void note_mismatch(string what);
			mismatches++;
			if (mismatches <= MAX_SHOWN) $display("tb: mismatch: %s", what);
		endfunction

		function void check_result(logic [DATA_W-1:0] value, logic [STAT_W-1:0] status);
			rpn_result_t want;
			if (awaited_results.size() == 0) begin
				note_mismatch($sformatf("unexpected result value %0d status %0d",
					$signed(value), status));
				return;
			end
			want = awaited_results.pop_front();
			status_seen[want.status]++;
			if (status !== want.status)
				note_mismatch($sformatf("status expected %0d actual %0d",
					want.status, status));
			if (value !== want.value)
				note_mismatch($sformatf("value expected %0d actual %0d",
					$signed(want.value), $signed(value)));
		endfunction

		function int pending();
			return awaited_results.size();
		endfunction
	endclass

	logic                clk = 1'b0;
	logic                arst_n = 1'b0;
	logic                s_tvalid = 1'b0;
	logic                s_tready;
	logic [SYM_W-1:0]    s_tdata = '0;   // [7:0] symbol
	logic                s_tlast = 1'b0; // last_symbol
	logic                m_tvalid;
	logic                m_tready = 1'b0;
	logic [DATA_W-1:0]   m_tdata;        // [31:0] value
	logic [STAT_W-1:0]   m_tuser;        // [1:0] status

	rpn_stack_tracker sb = new();

	int  symbols_sent = 0;
	int  exprs_sent   = 0;
	int  burst_left   = 1;
	bit  gaps_on      = 1'b1;
	int  holds_asked  = 0;
	int  holds_done   = 0;
	int  hold_left    = 0;
	int  rx_cycle     = 0;
	int  idle_cycles  = 0;

	postfix_expression_evaluator_unit #(
		.STACK_DEPTH(DEPTH)
	) uut (
		.clk     (clk),
		.arst_n  (arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata (s_tdata),
		.s_tlast (s_tlast),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata (m_tdata),
		.m_tuser (m_tuser)
	);

	always #1 clk = ~clk;

	// receiver: rotating stall patterns, plus long hold-offs on request
	always @(posedge clk) begin
		rx_cycle++;
		if (arst_n && m_tvalid && m_tready) sb.check_result(m_tdata, m_tuser);
		if (hold_left > 0) begin
			hold_left--;
			m_tready <= 1'b0;
		end else if (holds_done != holds_asked) begin
			holds_done++;
			hold_left = HOLD_CYCLES - 1;
			m_tready <= 1'b0;
		end else begin
			case (rx_pattern_t'((rx_cycle / 150) % 4))
				RX_FREE:   m_tready <= 1'b1;
				RX_COIN:   m_tready <= 1'($urandom_range(0, 1));
				RX_SPARSE: m_tready <= ($urandom_range(0, 4) == 0);
				default:   m_tready <= (rx_cycle % 16) < 10;
			endcase
		end
	end

	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) idle_cycles = 0;
		else idle_cycles++;
	end

	initial begin
		wait (idle_cycles >= IDLE_LIMIT);
		$display("tb: no transfer for %0d cycles", IDLE_LIMIT);
		$display("tb: FAIL");
		$finish;
	end

	function automatic logic [SYM_W-1:0] digit(int n);
		return SYM_ZERO + SYM_W'(n);
	endfunction

	function automatic logic [SYM_W-1:0] random_operator();
		return OPERATORS[$urandom_range(0, 4)];
	endfunction

	function automatic logic [SYM_W-1:0] random_operand();
		logic [SYM_W-1:0] s;
		if ($urandom_range(0, 6) != 0) return digit($urandom_range(0, 9));
		do s = SYM_W'($urandom_range(0, 255)); while (is_operator(s));
		return s;
	endfunction

	function automatic sym_q_t wellformed_expr(int n_operands);
		sym_q_t q;
		int depth = 0;
		int left = n_operands;
		bit stop_early = ($urandom_range(0, 5) == 0);
		while (left > 0 || (depth > 1 && !stop_early)) begin
			if (depth >= 2 && (left == 0 || $urandom_range(0, 2) == 0)) begin
				q.push_back(random_operator());
				depth--;
			end else begin
				q.push_back(random_operand());
				depth++;
				left--;
			end
		end
		return q;
	endfunction

	// pushes near or past the stack limit (DEPTH-6 to DEPTH+8), then up to four operators
	function automatic sym_q_t deep_expr();
		sym_q_t q;
		int n_push = $urandom_range(DEPTH - 6, DEPTH + 8);
		int n_ops = $urandom_range(0, 4);
		repeat (n_push) q.push_back(random_operand());
		repeat (n_ops) q.push_back(random_operator());
		return q;
	endfunction

	function automatic sym_q_t broken_expr();
		sym_q_t q;
		repeat ($urandom_range(1, 12))
			q.push_back($urandom_range(0, 1) ? random_operator() : random_operand());
		return q;
	endfunction

	function automatic sym_q_t noise_expr();
		sym_q_t q;
		repeat ($urandom_range(1, 10)) q.push_back(SYM_W'($urandom_range(0, 255)));
		return q;
	endfunction

	task automatic send_symbol(input logic [SYM_W-1:0] sym, input logic is_last);
		s_tvalid <= 1'b1;
		s_tdata  <= sym;
		s_tlast  <= is_last;
		@(posedge clk);
		while (!s_tready) @(posedge clk);
		sb.take_symbol(sym, is_last);
		symbols_sent++;
		burst_left--;
		if (burst_left <= 0) begin
			burst_left = $urandom_range(1, 24);
			if (gaps_on) begin
				s_tvalid <= 1'b0;
				repeat ($urandom_range(1, ($urandom_range(0, 3) == 0) ? 40 : 6))
					@(posedge clk);
			end
		end
	endtask

	task automatic send_expression(input sym_q_t q);
		foreach (q[i]) send_symbol(q[i], i == q.size() - 1);
		exprs_sent++;
	endtask

	// always waits on the clock before returning, so valid is never dropped and raised in one step
	task automatic drain_results();
		s_tvalid <= 1'b0;
		do @(posedge clk); while (sb.pending() != 0);
	endtask

	initial begin
		sym_q_t q;
		int expr_idx;
		int shape;

		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// byte extremes through xor, then add
		send_expression('{8'd0, 8'd255, SYM_XOR, digit(7), SYM_ADD});
		// operator on an empty stack
		send_expression('{SYM_ADD});
		// divide by zero stays sticky over a later underflow
		send_expression('{digit(9), digit(0), SYM_DIV, SYM_ADD});
		// build the most negative word, then divide it by minus one
		send_expression('{8'd176, 8'd176, SYM_MUL, 8'd176, SYM_MUL, 8'd176, SYM_MUL,
			digit(8), SYM_MUL, digit(0), digit(1), SYM_SUB, SYM_DIV});
		drain_results();

		expr_idx = 0;
		while (symbols_sent < N_SYMBOLS) begin
			shape = $urandom_range(0, 99);
			if (expr_idx % 18 == 7) q = deep_expr();
			else if (shape < 75) q = wellformed_expr($urandom_range(1, 8));
			else if (shape < 88) q = broken_expr();
			else q = noise_expr();
			gaps_on = ($urandom_range(0, 3) != 0);
			// receiver stops long enough for the output register and input to back up
			if (expr_idx == 20 || expr_idx == 45) holds_asked++;
			send_expression(q);
			if (expr_idx % 12 == 11) drain_results();
			expr_idx++;
		end

		drain_results();
		repeat (40) @(posedge clk);

		$display("tb: %0d symbols in %0d expressions, %0d mismatches", symbols_sent,
			exprs_sent, sb.mismatches);
		$display("tb: results ok %0d, underflow %0d, divide by zero %0d, stack full %0d",
			sb.status_seen[STAT_OK], sb.status_seen[STAT_UNDER],
			sb.status_seen[STAT_DIVZ], sb.status_seen[STAT_FULL]);
		if (sb.mismatches == 0 && sb.pending() == 0)
			$display("tb: PASS");
		else
			$display("tb: FAIL");
		$finish;
	end

endmodule
